/* design/rde_pkg.sv */
// shared constants, types and helpers for the radix digit emitter
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

    localparam int VALUE_W        = 64;   // width of the value field on the input port
    localparam int VALUE_BITS_DEF = 64;   // default for the number of value bits converted
    localparam int MAX_SYMBOLS    = 16;
    localparam int SYM_W          = 8;
    localparam int TABLE_W        = 128;  // both symbol registers side by side
    localparam int BASE_W         = 5;
    localparam int DIGIT_W        = 4;
    localparam int COUNT_W        = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int OUT_DATA_W     = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]     BASE_LENGTH_RST  = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    // classified item handed from the front to the back
    typedef struct packed {
        logic               bad_base;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [TABLE_W-1:0] tab,
        input logic [DIGIT_W-1:0] k
    );
        return tab[k*SYM_W +: SYM_W];
    endfunction

endpackage

`default_nettype wire

/* design/rde_front.sv */
// front end: accepts values, checks the symbol table and queues the result
`timescale 1ns / 1ps
`default_nettype none

module rde_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [rde_pkg::VALUE_W-1:0]   i_s_tdata,
    input  wire logic [rde_pkg::BASE_W-1:0]    i_base_length,
    input  wire logic [rde_pkg::TABLE_W-1:0]   i_symbols,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output rde_pkg::t_cmd                      o_cmd
);

    rde_pkg::t_cmd                    r_queue [rde_pkg::QUEUE_DEPTH];
    logic [rde_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [rde_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [rde_pkg::QCNT_W-1:0]       r_count;
    logic                             table_ok;
    logic [rde_pkg::SYM_W-1:0]        sym_a;
    logic                             push;
    logic                             pop;

    // symbol table check: length, sign characters, repeats
    always_comb begin
        table_ok = 1'b1;
        sym_a    = '0;
        if (i_base_length < rde_pkg::BASE_W'(2) ||
            i_base_length > rde_pkg::BASE_W'(rde_pkg::MAX_SYMBOLS)) begin
            table_ok = 1'b0;
        end
        for (int a = 0; a < rde_pkg::MAX_SYMBOLS; a++) begin
            sym_a = rde_pkg::symbol_at(i_symbols, rde_pkg::DIGIT_W'(a));
            if (rde_pkg::BASE_W'(a) < i_base_length) begin
                if (sym_a == rde_pkg::CHAR_PLUS || sym_a == rde_pkg::CHAR_MINUS) begin
                    table_ok = 1'b0;
                end
                for (int b = a + 1; b < rde_pkg::MAX_SYMBOLS; b++) begin
                    if (rde_pkg::BASE_W'(b) < i_base_length &&
                        rde_pkg::symbol_at(i_symbols, rde_pkg::DIGIT_W'(b)) == sym_a) begin
                        table_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign o_s_tready  = (r_count != rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH));
    assign push        = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= '{bad_base: !table_ok, value: i_s_tdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH))
        else $error("queue holds more words than it has entries");

endmodule

`default_nettype wire

/* design/rde_div.sv */
// iterative divider by a small radix, eight quotient bits a cycle
`timescale 1ns / 1ps
`default_nettype none

module rde_div #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [VALUE_BITS-1:0]         i_dividend,
    input  wire logic [rde_pkg::BASE_W-1:0]    i_radix,
    output logic                               o_done,
    output logic [VALUE_BITS-1:0]              o_quot,
    output logic [rde_pkg::DIGIT_W-1:0]        o_rem
);

    localparam int CHUNKS = (VALUE_BITS + 7) / 8;
    localparam int PAD_W  = CHUNKS * 8;
    localparam int LEFT_W = $clog2(CHUNKS + 1);

    logic [PAD_W-1:0]                r_num;   // dividend bits on top, quotient bits shift in below
    logic [rde_pkg::DIGIT_W-1:0]     r_rem;
    logic [LEFT_W-1:0]               r_left;
    logic                            r_busy;
    logic                            r_done;
    logic [7:0]                      top_byte;
    logic [7:0]                      q_byte;
    logic [rde_pkg::DIGIT_W-1:0]     n_rem;
    logic [rde_pkg::BASE_W-1:0]      trial;

    assign top_byte = r_num[PAD_W-1 -: 8];

    // restoring steps on a remainder that always stays below the radix
    always_comb begin
        n_rem  = r_rem;
        q_byte = '0;
        trial  = '0;
        for (int i = 7; i >= 0; i--) begin
            trial = {n_rem, top_byte[i]};
            if (trial >= i_radix) begin
                trial     = trial - i_radix;
                q_byte[i] = 1'b1;
            end
            n_rem = trial[rde_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PAD_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= PAD_W'({r_num, q_byte});
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= LEFT_W'(CHUNKS);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[VALUE_BITS-1:0];
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* design/rde_back.sv */
// back end: splits a value into digits, stacks them and sends them out msd first
`timescale 1ns / 1ps
`default_nettype none

module rde_back #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_ready,
    input  wire rde_pkg::t_cmd                 i_cmd,
    input  wire logic [rde_pkg::BASE_W-1:0]    i_radix,
    input  wire logic [rde_pkg::TABLE_W-1:0]   i_symbols,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rde_pkg::SYM_W-1:0]          o_symbol_char,
    output logic                               o_last,
    output logic                               o_bad_base,
    output logic [rde_pkg::COUNT_W-1:0]        o_char_count
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_SHOW = 4'b1000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [rde_pkg::DIGIT_W-1:0]     r_mem [VALUE_BITS];
    logic [rde_pkg::DIGIT_W-1:0]     r_rd_digit;
    logic [CNT_W-1:0]                r_cnt;
    logic [CNT_W-1:0]                r_total;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_bad;
    logic                            r_last;
    logic                            div_start;
    logic [VALUE_BITS-1:0]           div_dividend;
    logic                            div_done;
    logic [VALUE_BITS-1:0]           div_quot;
    logic [rde_pkg::DIGIT_W-1:0]     div_rem;
    logic                            take_cmd;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign take_cmd    = i_cmd_valid && o_cmd_ready;

    // first digit from the new value, later ones from the last quotient
    assign div_start    = (take_cmd && !i_cmd.bad_base) ||
                          (r_state == ST_DIV && div_done && div_quot != '0);
    assign div_dividend = (r_state == ST_IDLE) ? i_cmd.value[VALUE_BITS-1:0] : div_quot;

    rde_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (i_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take_cmd) n_state = i_cmd.bad_base ? ST_SHOW : ST_DIV;
            end
            ST_DIV: begin
                if (div_done && div_quot == '0) n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_out_ready) n_state = r_last ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // digit stack, least significant digit at the lowest address
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_mem[r_cnt[IDX_W-1:0]] <= div_rem;
        end
        if (r_state == ST_RD) begin
            r_rd_digit <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_bad   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (take_cmd) begin
                        r_bad  <= i_cmd.bad_base;
                        r_last <= i_cmd.bad_base;
                        r_cnt  <= '0;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (div_quot == '0) begin
                            r_total <= r_cnt + 1'b1;
                            r_idx   <= r_cnt[IDX_W-1:0];
                        end
                    end
                end
                ST_RD: begin
                    r_last <= (r_idx == '0);
                end
                ST_SHOW: begin
                    if (i_out_ready && !r_last) r_idx <= r_idx - 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = (r_state == ST_SHOW);
    assign o_last        = r_last;
    assign o_bad_base    = r_bad;
    assign o_symbol_char = r_bad ? '0 : rde_pkg::symbol_at(i_symbols, r_rd_digit);
    assign o_char_count  = (r_last && !r_bad) ? rde_pkg::COUNT_W'(r_total) : '0;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHOW && r_bad) |-> r_last)
        else $error("bad base word not marked last");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHOW && i_out_ready && r_last) |=> (r_state == ST_IDLE))
        else $error("no return to idle after the last word");

endmodule

`default_nettype wire

/* design/radix_digit_emitter_core.sv */
// top level of the radix digit emitter: config registers, front and back
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  width  contents
// s stream   in         64     value
// m stream   out        16     symbol_char, char_count; tlast = last, tuser = bad_base
// cfg        in         64     base_length, symbols_low, symbols_high by index
//
// one value with d digits takes d divider passes to split, the divider retiring
// eight quotient bits a cycle, and each digit is then sent while the sink is ready
// (stack read, then the output word)
// a bad symbol table costs one word and skips the divider altogether
// synchronous active-low reset restores the decimal table and empties the queue
// the two-entry queue keeps taking values while the back end waits on the sink

module radix_digit_emitter_core #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [rde_pkg::VALUE_W-1:0]       i_s_tdata,   // value
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [rde_pkg::OUT_DATA_W-1:0]         o_m_tdata,   // symbol_char, char_count
    output logic                                   o_m_tlast,
    output logic                                   o_m_tuser,   // bad_base
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [rde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // config registers; the user must write them only while the core is idle, the block does not enforce it
    logic [rde_pkg::BASE_W-1:0]      r_base_length;
    logic [rde_pkg::CFG_DATA_W-1:0]  r_symbols_low;
    logic [rde_pkg::CFG_DATA_W-1:0]  r_symbols_high;
    logic [rde_pkg::TABLE_W-1:0]     symbols;

    // front to back queue handshake
    logic                            cmd_valid;
    logic                            cmd_ready;
    rde_pkg::t_cmd                   cmd;

    // back end result word
    logic [rde_pkg::SYM_W-1:0]       symbol_char;
    logic [rde_pkg::COUNT_W-1:0]     char_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length  <= rde_pkg::BASE_LENGTH_RST;
            r_symbols_low  <= rde_pkg::SYMBOLS_LOW_RST;
            r_symbols_high <= rde_pkg::SYMBOLS_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rde_pkg::CFG_BASE_LENGTH:  r_base_length  <= i_cfg_wdata[rde_pkg::BASE_W-1:0];
                rde_pkg::CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_wdata;
                rde_pkg::CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_wdata;
                default: ;  // no register at this index
            endcase
        end
    end

    // symbol byte k sits at bits 8k+7:8k of the joined table
    assign symbols = {r_symbols_high, r_symbols_low};

    // front: accept and classify against the current table
    rde_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_base_length (r_base_length),
        .i_symbols     (symbols),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_ready   (cmd_ready),
        .o_cmd         (cmd)
    );

    // back: divide, stack the digits, emit most significant first
    rde_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .i_radix       (r_base_length),
        .i_symbols     (symbols),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_symbol_char (symbol_char),
        .o_last        (o_m_tlast),
        .o_bad_base    (o_m_tuser),
        .o_char_count  (char_count)
    );

    // pack the word, top bit padding
    assign o_m_tdata = {1'b0, char_count, symbol_char};

endmodule

`default_nettype wire

/* verif/radix_digit_emitter_core_checker.sv */
// checker for the radix digit emitter: predicts every output word and compares it
`timescale 1ns / 1ps

module radix_digit_emitter_core_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [rde_pkg::VALUE_W-1:0]    i_s_tdata,    // value
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [rde_pkg::OUT_DATA_W-1:0] i_m_tdata,    // symbol_char, char_count
    input  wire logic                           i_m_tlast,
    input  wire logic                           i_m_tuser,    // bad_base
    input  wire logic                           i_cfg_we,
    input  wire logic [rde_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rde_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_words_checked
);

    import rde_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0]   glyph;
        logic               last;
        logic               bad_base;
        logic [COUNT_W-1:0] count;
    } digit_word_t;

    digit_word_t        words_due[$];
    logic [BASE_W-1:0]  radix_len;
    logic [TABLE_W-1:0] glyphs;
    int                 fails   = 0;
    int                 checked = 0;

    function automatic logic [SYM_W-1:0] glyph_of(input int k);
        return glyphs[k*SYM_W +: SYM_W];
    endfunction

    // a table is usable with 2..16 distinct symbols and no sign character
    function automatic bit table_usable();
        int n;
        n = radix_len;
        if (n < 2 || n > MAX_SYMBOLS)
            return 1'b0;
        for (int a = 0; a < n; a++) begin
            if (glyph_of(a) == CHAR_PLUS || glyph_of(a) == CHAR_MINUS)
                return 1'b0;
            for (int b = a + 1; b < n; b++)
                if (glyph_of(b) == glyph_of(a))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue the digit words of one value, most significant digit first
    function automatic void spell_value(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] stack [64];
        logic [63:0]        rest;
        logic [63:0]        radix;
        int                 n;
        digit_word_t        w;
        if (!table_usable()) begin
            w = '{glyph: '0, last: 1'b1, bad_base: 1'b1, count: '0};
            words_due.push_back(w);
            return;
        end
        radix = 64'(radix_len);
        rest  = (VALUE_BITS_DEF >= 64) ? value : value & ((64'd1 << VALUE_BITS_DEF) - 64'd1);
        n     = 0;
        do begin
            stack[n] = DIGIT_W'(rest % radix);
            rest     = rest / radix;
            n++;
        end while (rest != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--) begin
            w.glyph    = glyph_of(stack[k]);
            w.last     = (k == 0);
            w.bad_base = 1'b0;
            w.count    = (k == 0) ? COUNT_W'(n) : '0;
            words_due.push_back(w);
        end
    endfunction

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        digit_word_t got;
        digit_word_t want;
        if (!i_rst_n) begin
            radix_len = BASE_LENGTH_RST;
            glyphs    = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};
            words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_LENGTH:  radix_len       = i_cfg_wdata[BASE_W-1:0];
                    CFG_SYMBOLS_LOW:  glyphs[63:0]    = i_cfg_wdata;
                    CFG_SYMBOLS_HIGH: glyphs[127:64]  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // check the outgoing word before queueing a new value's words
            if (i_m_tvalid && i_m_tready) begin
                got = '{glyph: i_m_tdata[SYM_W-1:0], last: i_m_tlast, bad_base: i_m_tuser,
                        count: i_m_tdata[SYM_W +: COUNT_W]};
                checked++;
                if (words_due.size() == 0) begin
                    $error("unexpected word: symbol_char 0x%0h last %0b bad_base %0b count %0d",
                           got.glyph, got.last, got.bad_base, got.count);
                    fails++;
                end else begin
                    want = words_due.pop_front();
                    compare_field("symbol_char", want.glyph, got.glyph);
                    compare_field("last", 8'(want.last), 8'(got.last));
                    compare_field("bad_base", 8'(want.bad_base), 8'(got.bad_base));
                    compare_field("char_count", 8'(want.count), 8'(got.count));
                end
            end
            if (i_s_tvalid && i_s_tready)
                spell_value(i_s_tdata);
        end
        o_pending       <= words_due.size();
        o_fail_count    <= fails;
        o_words_checked <= checked;
    end

endmodule

/* verif/radix_digit_emitter_core_tb.sv */
// testbench top for the radix digit emitter: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module radix_digit_emitter_core_tb;

    import rde_pkg::*;

    localparam int HOLD_CYCLES    = 400;   // long sink hold-off, enough to fill the queue
    localparam int WATCHDOG_LIMIT = 5000;  // well above the time a 64-digit binary value takes to split
    localparam int SETTLE_CYCLES  = 12;    // idle margin before touching the registers
    localparam int END_CYCLES     = 40;
    localparam int PHASE_ITEMS    = 95;
    localparam int HOLD_ITEMS     = 24;

    // ways of spoiling an otherwise good symbol table
    typedef enum int {SPOIL_REPEAT, SPOIL_PLUS, SPOIL_MINUS, SPOIL_LENGTH} spoil_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [VALUE_W-1:0]    i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BASE_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int words_checked;

    int send_idle_pct = 0;   // chance in a hundred that the source idles rather than offering
    int stall_pct     = 0;   // chance in a hundred that the sink is not ready
    bit hold_go       = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int values_sent   = 0;
    int tables_loaded = 0;

    radix_digit_emitter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    radix_digit_emitter_core_checker spelling_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .i_m_tuser       (o_m_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sink side: random stalls, plus one long hold-off counted here once requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: a stretch that reaches the watchdog limit with no word moving on either stream ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("radix_digit_emitter_core_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly short values so that binary tables stay quick, now and then the extremes
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = v >> $urandom_range(63, 44);
            default: v = v >> $urandom_range(63, 0);
        endcase
        return v;
    endfunction

    // random table: distinct symbols, sign characters kept out; one in five spoilt
    function automatic void pick_table(output logic [BASE_W-1:0] len,
                                       output logic [TABLE_W-1:0] tab);
        bit         taken [256];
        logic [7:0] b;
        int         a;
        int         c;
        spoil_t     how;
        taken = '{default: 1'b0};
        len   = BASE_W'($urandom_range(16, 2));
        tab   = {$urandom, $urandom, $urandom, $urandom};   // unused bytes stay as noise
        for (int k = 0; k < len; k++) begin
            do b = 8'($urandom); while (taken[b] || b == CHAR_PLUS || b == CHAR_MINUS);
            taken[b]       = 1'b1;
            tab[k*8 +: 8]  = b;
        end
        if ($urandom_range(4) == 0) begin
            how = spoil_t'($urandom_range(3));
            a   = $urandom_range(len - 1);
            c   = (a + 1 + $urandom_range(len - 2)) % len;
            case (how)
                SPOIL_REPEAT: tab[c*8 +: 8] = tab[a*8 +: 8];
                SPOIL_PLUS:   tab[a*8 +: 8] = CHAR_PLUS;
                SPOIL_MINUS:  tab[a*8 +: 8] = CHAR_MINUS;
                SPOIL_LENGTH: len = $urandom_range(1) ? BASE_W'($urandom_range(1))
                                                      : BASE_W'($urandom_range(31, 17));
            endcase
        end
    endfunction

    // offer one value, with random idle cycles ahead of it; returns on the accepting edge
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        values_sent++;
    endtask

    // stop offering and wait until every predicted word has gone out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers while the block is idle; junk above the length field
    task automatic load_table(input logic [BASE_W-1:0] len, input logic [TABLE_W-1:0] tab);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE_LENGTH;
        i_cfg_wdata <= {32'($urandom), 27'($urandom), len};
        @(posedge i_clk);
        i_cfg_index <= CFG_SYMBOLS_LOW;
        i_cfg_wdata <= tab[63:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SYMBOLS_HIGH;
        i_cfg_wdata <= tab[127:64];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tables_loaded++;
    endtask

    initial begin
        logic [BASE_W-1:0]  len;
        logic [TABLE_W-1:0] tab;
        int                 burst;
        int                 phase_count;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: decimal table straight out of reset
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);

        // binary: the 64-digit case and the single zero digit
        load_table(5'd2, {64'h0, 64'h3130});
        send_value(64'd0);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd5);

        // hex with an all-ones symbol at the top slot
        load_table(5'd16, {64'hFF45_4443_4241_3938, SYMBOLS_LOW_RST});
        send_value('1);
        send_value(64'd0);
        send_value(64'h0123_4567_89AB_CDEF);

        // base 3 whose first symbol is a nul byte
        load_table(5'd3, {64'h0, 64'h0000_0000_0062_6100});
        send_value(64'd0);
        send_value(64'd7);

        // bad tables: too short, too long, repeated symbol, plus sign, minus sign
        load_table(5'd0, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
        send_value(random_value());
        load_table(5'd1, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
        send_value(random_value());
        load_table(5'd17, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
        send_value(random_value());
        load_table(5'd31, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
        send_value(random_value());
        load_table(5'd2, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
        send_value(random_value());
        load_table(5'd10, {SYMBOLS_HIGH_RST, 64'h3736_3534_2B32_3130});
        send_value(random_value());
        load_table(5'd16, {64'h2D45_4443_4241_3938, SYMBOLS_LOW_RST});
        send_value(random_value());

        // random part: four idling mixes, a fresh table every short burst
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 79; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 79; end
                default: begin send_idle_pct = 11; stall_pct <= 11; end
            endcase
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                pick_table(len, tab);
                load_table(len, tab);
                burst = $urandom_range(18, 6);
                repeat (burst) send_value(random_value());
                phase_count += burst;
            end
        end

        // back-pressure: sink holds off for a long stretch while the source keeps going
        send_idle_pct = 0;
        stall_pct    <= 0;
        load_table(5'd10, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
        hold_go <= 1'b1;
        repeat (HOLD_ITEMS) send_value(random_value());

        // source pauses until every word is out, then the tail margin
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("run covered %0d values under %0d symbol tables, bases 2 to 16 and bad ones",
                 values_sent, tables_loaded);
        $display("%0d digit words compared, %0d field mismatches", words_checked, fail_count);
        if (fail_count == 0)
            $display("radix_digit_emitter_core_tb: clean");
        else
            $display("radix_digit_emitter_core_tb: errors");
        $finish;
    end

endmodule
